// File: src/rmf_pkg.sv
// Shared types, widths and register codes for the reflect-padded median filter.
`default_nettype none

package rmf_pkg;

  localparam int PIX_W        = 8;
  localparam int NCH          = 3;
  localparam int PXW          = PIX_W * NCH;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CHAN_REG_W   = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;
  localparam int ROW_W        = 13;
  localparam int MIN_DIM      = 4;
  localparam int MAX_HEIGHT   = 4096;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET    = 11'd256;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET   = 13'd256;
  localparam logic [CHAN_REG_W-1:0]   CHANNELS_RESET = 2'd3;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [PXW-1:0]   pxl_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_CHANNELS
  } cfg_reg_t;

endpackage

`default_nettype wire

// File: src/rmf_ifs.sv
// Pixel and result stream interfaces of the median filter.
`default_nettype none

interface rmf_pixel_if import rmf_pkg::*; ();
  logic valid;
  logic ready;
  logic mode;
  pix_t sample_a;
  pix_t sample_b;
  pix_t sample_c;

  modport source (output valid, mode, sample_a, sample_b, sample_c, input ready);
  modport sink (input valid, mode, sample_a, sample_b, sample_c, output ready);
endinterface

interface rmf_result_if import rmf_pkg::*; ();
  logic valid;
  logic ready;
  pix_t median_a;
  pix_t median_b;
  pix_t median_c;
  logic last_of_run;
  logic end_of_frame;

  modport source (output valid, median_a, median_b, median_c, last_of_run, end_of_frame,
                  input ready);
  modport sink (input valid, median_a, median_b, median_c, last_of_run, end_of_frame,
                output ready);
endinterface

`default_nettype wire

// File: src/rmf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: src/rmf_median.sv
// Rank-based median of one window of 8-bit samples.
`default_nettype none

module rmf_median import rmf_pkg::*; #(
  parameter int N = 9
) (
  input  pix_t vals [N],
  output pix_t median
);

  localparam int MID = N / 2;
  localparam int RKW = $clog2(N);

  // Ties broken by position, so exactly one element has rank MID.
  always_comb begin
    logic [N-1:0]   ahead;
    logic [RKW-1:0] rank;
    pix_t           acc;
    acc = '0;
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        ahead[j] = (vals[j] < vals[i]) || ((vals[j] == vals[i]) && (j < i));
      end
      rank = RKW'($countones(ahead));
      if (rank == RKW'(MID)) begin
        acc = acc | vals[i];
      end
    end
    median = acc;
  end

endmodule

`default_nettype wire

// File: src/reflect_padded_median_filter_core.sv
// Top level of the streaming reflect-padded median filter.
`default_nettype none

// Streaming SIDE x SIDE median filter (SIDE = 2*(WIN/2)+1) for up to three 8-bit
// channels, with mirrored borders that repeat the edge pixel. Pixels arrive in
// raster order; after the last image row the source sends WIN/2 rows of drain
// transactions (mode = 1) to flush the bottom border. A drain transaction inside
// the image rows is dropped; a pixel inside the drain rows counts as a drain step.
// Rate: one input transaction per clock while the pipeline can take it. The last pixel
// of every row from row WIN/2 on yields WIN/2+1 results and holds the input while
// the right-border results leave. The window stage emits one result per cycle while
// the window registers are free; that stage sets the burst cost. An accepted pixel
// passes through the line store read, column shift, window select and median result
// registers. The line store is SIDE RAMs of MAX_WIDTH pixels, one per line slot; it
// needs no clearing pass. Configuration writes take effect at once and restart the
// frame.
module reflect_padded_median_filter_core import rmf_pkg::*; #(
  parameter int WIN       = 3,
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  rmf_pixel_if.sink                   pixels,
  rmf_result_if.source                results
);

  localparam int PAD  = WIN / 2;
  localparam int SIDE = 2 * PAD + 1;
  localparam int NWIN = SIDE * SIDE;
  localparam int SLW  = $clog2(SIDE);
  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int CW1  = $clog2(MAX_WIDTH + 1);
  localparam int WCW  = (CW1 > WIDTH_REG_W) ? CW1 : WIDTH_REG_W;
  localparam int EW   = $clog2(PAD + 2);

  localparam logic signed [CW+1:0] PAD_S = (CW + 2)'(PAD);
  localparam logic signed [CW+1:0] ONE_S = (CW + 2)'(1);

  // ---------------------------------------------------------------------------
  // Configuration registers and frame position
  // ---------------------------------------------------------------------------
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  logic [CHAN_REG_W-1:0]   channels_reg;

  logic [CW-1:0]    col_count;
  logic [ROW_W-1:0] row_count;
  logic [SLW-1:0]   row_slot;     // row_count mod SIDE

  logic cfg_hit;
  assign cfg_hit = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT ||
                              cfg_index == CFG_CHANNELS);

  // Effective frame size after clamping
  logic [CW-1:0]    w_last;
  logic [ROW_W-1:0] h_eff;
  logic [ROW_W-1:0] h_last_row;   // last drain row index
  logic [WCW-1:0]   wr_ext;

  always_comb begin
    wr_ext = WCW'(width_reg);
    if (wr_ext < WCW'(MIN_DIM)) begin
      w_last = CW'(MIN_DIM - 1);
    end else if (wr_ext > WCW'(MAX_WIDTH)) begin
      w_last = CW'(MAX_WIDTH - 1);
    end else begin
      w_last = CW'(wr_ext - WCW'(1));
    end
    if (height_reg < HEIGHT_REG_W'(MIN_DIM)) begin
      h_eff = ROW_W'(MIN_DIM);
    end else if (height_reg > HEIGHT_REG_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = ROW_W'(height_reg);
    end
    h_last_row = h_eff + ROW_W'(PAD) - ROW_W'(1);
  end

  logic [CHAN_REG_W-1:0] ch_used;
  assign ch_used = (channels_reg == '0) ? CHAN_REG_W'(1) : channels_reg;

  // ---------------------------------------------------------------------------
  // Stage 0: input transaction, line store write and read issue
  // ---------------------------------------------------------------------------
  logic s1_free;
  logic accept, drain0, skip0, adv0;
  logic col_end, row_last;
  logic [EW-1:0]  nres0;
  logic           eof0;
  logic [SLW-1:0] slot_map0 [SIDE];

  assign pixels.ready = s1_free && !rst;
  assign accept   = pixels.valid && pixels.ready;
  assign drain0   = row_count >= h_eff;
  assign skip0    = pixels.mode && !drain0;       // drain inside image rows is dropped
  assign adv0     = accept && !skip0;
  assign col_end  = col_count == w_last;
  assign row_last = row_count == h_last_row;
  assign eof0     = row_last && col_end;

  // From row PAD on, one result per pixel from column PAD on and PAD more at the end of the row.
  always_comb begin
    if (row_count < ROW_W'(PAD)) begin
      nres0 = '0;
    end else if (col_end) begin
      nres0 = EW'(PAD + 1);
    end else if (col_count >= CW'(PAD)) begin
      nres0 = EW'(1);
    end else begin
      nres0 = '0;
    end
  end

  // Line slot of each window row, with top and bottom reflection.
  always_comb begin
    logic [SLW:0]     rel_sum;
    logic [SLW-1:0]   rel;
    logic [ROW_W:0]   rsum;
    logic [ROW_W:0]   dd;
    logic [SLW:0]     tw;
    logic [SLW:0]     bsum;
    logic [ROW_W-1:0] mtop;
    for (int dr = 0; dr < SIDE; dr++) begin
      rel_sum = (SLW + 1)'(row_slot) + (SLW + 1)'(dr + 1);
      rel = (rel_sum >= (SLW + 1)'(SIDE)) ? SLW'(rel_sum - (SLW + 1)'(SIDE)) : SLW'(rel_sum);
      rsum = (ROW_W + 1)'(row_count) + (ROW_W + 1)'(dr);
      mtop = ROW_W'(2 * PAD - dr - 1) - row_count;
      dd = rsum + (ROW_W + 1)'(1) - (ROW_W + 1)'(h_eff) - (ROW_W + 1)'(2 * PAD);
      tw = {dd[SLW-1:0], 1'b0} - (SLW + 1)'(1);
      bsum = (SLW + 1)'(rel) + (SLW + 1)'(SIDE) - tw;
      if (row_count < ROW_W'(2 * PAD - dr)) begin
        slot_map0[dr] = mtop[SLW-1:0];              // above the top edge
      end else if (rsum >= (ROW_W + 1)'(h_eff) + (ROW_W + 1)'(2 * PAD)) begin
        slot_map0[dr] = (bsum >= (SLW + 1)'(SIDE)) ? SLW'(bsum - (SLW + 1)'(SIDE))
                                                   : SLW'(bsum);  // below the bottom
      end else begin
        slot_map0[dr] = rel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg    <= WIDTH_RESET;
      height_reg   <= HEIGHT_RESET;
      channels_reg <= CHANNELS_RESET;
      col_count    <= '0;
      row_count    <= '0;
      row_slot     <= '0;
    end else if (cfg_hit) begin
      case (cfg_index)
        CFG_WIDTH:    width_reg    <= cfg_data[WIDTH_REG_W-1:0];
        CFG_HEIGHT:   height_reg   <= cfg_data[HEIGHT_REG_W-1:0];
        CFG_CHANNELS: channels_reg <= cfg_data[CHAN_REG_W-1:0];
        default: ;
      endcase
      col_count <= '0;
      row_count <= '0;
      row_slot  <= '0;
    end else if (adv0) begin
      if (col_end) begin
        col_count <= '0;
        if (row_last) begin
          row_count <= '0;
          row_slot  <= '0;
        end else begin
          row_count <= row_count + ROW_W'(1);
          row_slot  <= (row_slot == SLW'(SIDE - 1)) ? '0 : row_slot + SLW'(1);
        end
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // Line store: one RAM per line slot
  pxl_t pix0;
  pxl_t ram_q [SIDE];
  assign pix0 = {pixels.sample_c, pixels.sample_b, pixels.sample_a};

  for (genvar i = 0; i < SIDE; i++) begin : g_line
    rmf_ram #(
      .WIDTH (PXW),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (adv0 && !drain0 && row_slot == SLW'(i)),
      .waddr (col_count),
      .wdata (pix0),
      .re    (adv0),
      .raddr (col_count),
      .rdata (ram_q[i])
    );
  end

  // ---------------------------------------------------------------------------
  // Stage 1: line store data back, build the new window column
  // ---------------------------------------------------------------------------
  logic           v1;
  pxl_t           pix1;
  logic [CW-1:0]  col1;
  logic [SLW-1:0] slot_map1 [SIDE];
  logic [SLW-1:0] cur_slot1;
  logic           drain1;
  logic [EW-1:0]  nres1;
  logic           eof1;

  logic s2_free, mv1;
  assign s1_free = !v1 || s2_free;
  assign mv1     = v1 && s2_free;

  // The current row's pixel was written together with the read, so the RAM returns old data; take it directly.
  pxl_t new_col [SIDE];
  always_comb begin
    for (int dr = 0; dr < SIDE; dr++) begin
      new_col[dr] = (!drain1 && slot_map1[dr] == cur_slot1) ? pix1 : ram_q[slot_map1[dr]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv0) begin
      v1 <= 1'b1;
    end else if (mv1) begin
      v1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv0) begin
      pix1      <= pix0;
      col1      <= col_count;
      slot_map1 <= slot_map0;
      cur_slot1 <= row_slot;
      drain1    <= drain0;
      nres1     <= nres0;
      eof1      <= eof0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: column window, one result per cycle while stage 3 is free (bursts at row end)
  // ---------------------------------------------------------------------------
  pxl_t          colwin [SIDE][SIDE];   // [age][row], age 0 = newest column
  logic [CW-1:0] col2;
  logic [EW-1:0] e2;                    // how far the output column lags col2
  logic [EW-1:0] left2;                 // results still to emit
  logic          eof2;

  logic s3_free, emit;
  assign emit    = (left2 != '0) && s3_free;
  assign s2_free = (left2 == '0) || ((left2 == EW'(1)) && s3_free);

  // Column age for each window column, with left and right reflection.
  logic [SLW-1:0] sel_pos [SIDE];
  pxl_t           win_sel [SIDE][SIDE];
  always_comb begin
    logic signed [CW+1:0] colx;
    logic signed [CW+1:0] vpos;
    logic signed [CW+1:0] ppos;
    colx = $signed({2'b00, col2});
    for (int dc = 0; dc < SIDE; dc++) begin
      vpos = colx - $signed({{(CW + 2 - EW){1'b0}}, e2}) - PAD_S + (CW + 2)'(dc);
      if (vpos < 0) begin
        ppos = colx + vpos + ONE_S;
      end else if (vpos > colx) begin
        ppos = vpos - colx - ONE_S;
      end else begin
        ppos = colx - vpos;
      end
      sel_pos[dc] = ppos[SLW-1:0];
    end
    for (int dr = 0; dr < SIDE; dr++) begin
      for (int dc = 0; dc < SIDE; dc++) begin
        win_sel[dr][dc] = colwin[sel_pos[dc]][dr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left2 <= '0;
    end else if (mv1) begin
      left2 <= nres1;
    end else if (emit) begin
      left2 <= left2 - EW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mv1) begin
      col2      <= col1;
      e2        <= EW'(PAD);
      eof2      <= eof1;
      colwin[0] <= new_col;
      for (int k = 1; k < SIDE; k++) begin
        colwin[k] <= colwin[k-1];
      end
    end else if (emit) begin
      e2 <= e2 - EW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: window registers
  // ---------------------------------------------------------------------------
  logic v3;
  pxl_t win3 [SIDE][SIDE];
  logic last3;
  logic eof3;

  logic v4, out_free, mv3;
  assign out_free = !v4 || results.ready;
  assign s3_free  = !v3 || out_free;
  assign mv3      = v3 && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (emit) begin
      v3 <= 1'b1;
    end else if (mv3) begin
      v3 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      win3  <= win_sel;
      last3 <= left2 == EW'(1);
      eof3  <= eof2 && (left2 == EW'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: medians and result register
  // ---------------------------------------------------------------------------
  pix_t ch_vals [NCH][NWIN];
  pix_t med [NCH];
  pix_t med_r [NCH];
  logic last_r;
  logic eof_r;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      for (int dr = 0; dr < SIDE; dr++) begin
        for (int dc = 0; dc < SIDE; dc++) begin
          ch_vals[c][dr*SIDE+dc] = win3[dr][dc][c*PIX_W +: PIX_W];
        end
      end
    end
  end

  for (genvar c = 0; c < NCH; c++) begin : g_chan
    rmf_median #(
      .N (NWIN)
    ) u_median (
      .vals   (ch_vals[c]),
      .median (med[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (mv3) begin
      v4 <= 1'b1;
    end else if (results.ready) begin
      v4 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mv3) begin
      for (int c = 0; c < NCH; c++) begin
        med_r[c] <= (CHAN_REG_W'(c) < ch_used) ? med[c] : '0;
      end
      last_r <= last3;
      eof_r  <= eof3;
    end
  end

  assign results.valid        = v4;
  assign results.median_a     = med_r[0];
  assign results.median_b     = med_r[1];
  assign results.median_c     = med_r[2];
  assign results.last_of_run  = last_r;
  assign results.end_of_frame = eof_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Frame end always sends both counters and the line slot back to the start.
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    (adv0 && eof0 && !cfg_hit) |=> (row_count == '0 && col_count == '0 && row_slot == '0))
    else $error("frame position did not wrap after the last drain step");

  // A burst walks the output column toward the row end in step with its count.
  a_burst_track: assert property (@(posedge clk) disable iff (rst)
    (left2 > EW'(1)) |-> (e2 == left2 - EW'(1)))
    else $error("burst column offset out of step with remaining count");

  // The frame-end mark only rides on the last result of a transaction.
  a_eof_last: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.end_of_frame) |-> results.last_of_run)
    else $error("end_of_frame without last_of_run");

endmodule

`default_nettype wire
